// ===== rtl/des_pkg.sv =====
package des_pkg;

    localparam int Rounds = 16;
    localparam int HalfKeyBits = 28;
    localparam int AddrBits = 3;
    localparam logic [AddrBits-1:0] AddrKey = 3'd0;

    typedef logic [7:0] tab_idx_t;

    typedef struct packed {
        logic        dec;
        logic [31:0] l;
        logic [31:0] r;
    } round_data_t;

    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        tab_idx_t tab [64];
        tab = '{8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,
                8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
                8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,
                8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
                8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,
                8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
                8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,
                8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};
        for (int i = 0; i < 64; i++)
        begin
            r[63-i] = v[64-int'(tab[i])];
        end
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        tab_idx_t tab [64];
        tab = '{8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32,
                8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
                8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30,
                8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
                8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28,
                8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
                8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26,
                8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};
        for (int i = 0; i < 64; i++)
        begin
            r[63-i] = v[64-int'(tab[i])];
        end
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        tab_idx_t tab [56];
        tab = '{8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd58,8'd50,8'd42,8'd34,
                8'd26,8'd18,8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
                8'd60,8'd52,8'd44,8'd36,8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7,
                8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,
                8'd29,8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};
        for (int i = 0; i < 56; i++)
        begin
            r[55-i] = v[64-int'(tab[i])];
        end
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        tab_idx_t tab [48];
        tab = '{8'd14,8'd17,8'd11,8'd24,8'd1,8'd5,8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
                8'd23,8'd19,8'd12,8'd4,8'd26,8'd8,8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
                8'd41,8'd52,8'd31,8'd37,8'd47,8'd55,8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
                8'd44,8'd49,8'd39,8'd56,8'd34,8'd53,8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};
        for (int i = 0; i < 48; i++)
        begin
            r[47-i] = v[56-int'(tab[i])];
        end
        return r;
    endfunction

    function automatic logic [47:0] perm_e(input logic [31:0] v);
        logic [47:0] r;
        tab_idx_t tab [48];
        tab = '{8'd32,8'd1,8'd2,8'd3,8'd4,8'd5,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
                8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
                8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
                8'd24,8'd25,8'd26,8'd27,8'd28,8'd29,8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};
        for (int i = 0; i < 48; i++)
        begin
            r[47-i] = v[32-int'(tab[i])];
        end
        return r;
    endfunction

    function automatic logic [31:0] perm_p(input logic [31:0] v);
        logic [31:0] r;
        tab_idx_t tab [32];
        tab = '{8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17,
                8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
                8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,
                8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};
        for (int i = 0; i < 32; i++)
        begin
            r[31-i] = v[32-int'(tab[i])];
        end
        return r;
    endfunction

    // s-box lookup, box 0 is S1
    function automatic logic [3:0] sbox(input logic [2:0] box, input logic [5:0] six);
        logic [3:0] t [8][64];
        logic [5:0] idx;
        t[0] = '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
                 4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
                 4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
                 4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13};
        t[1] = '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
                 4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
                 4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
                 4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9};
        t[2] = '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
                 4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
                 4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
                 4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12};
        t[3] = '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
                 4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
                 4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
                 4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14};
        t[4] = '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
                 4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
                 4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
                 4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3};
        t[5] = '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
                 4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
                 4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
                 4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13};
        t[6] = '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
                 4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
                 4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
                 4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12};
        t[7] = '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
                 4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
                 4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
                 4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11};
        idx = {six[5], six[0], six[4:1]};
        return t[box][idx];
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] o;
        x = perm_e(r) ^ k;
        for (int i = 0; i < 8; i++)
        begin
            o[31-4*i -: 4] = sbox(3'(i), x[47-6*i -: 6]);
        end
        return perm_p(o);
    endfunction

    function automatic logic [27:0] rotl28(input logic [27:0] x, input int s);
        logic [55:0] d;
        d = {x, x} << s;
        return d[55:28];
    endfunction

endpackage

// ===== rtl/des_key_sched.sv =====
module des_key_sched
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_load,
    input  logic [63:0] key_value,
    output logic [63:0] key_out,
    output logic [47:0] sub_key [des_pkg::Rounds]
);

    logic [63:0] key_reg;
    logic [55:0] cd_reg;
    logic [47:0] round_keys [des_pkg::Rounds];
    logic [55:0] cd_next;

    assign cd_next = des_pkg::perm_pc1(key_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (key_load)
        begin
            key_reg <= key_value;
        end
    end

    // round keys derived combinationally from the registered halves, one per round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg <= des_pkg::perm_pc1('0);
        end
        else if (key_load)
        begin
            cd_reg <= cd_next;
        end
    end

    always_comb
    begin
        logic [27:0] c;
        logic [27:0] d;
        c = cd_reg[55:28];
        d = cd_reg[27:0];
        for (int i = 0; i < des_pkg::Rounds; i++)
        begin
            if (i == 0 || i == 1 || i == 8 || i == 15)
            begin
                c = des_pkg::rotl28(c, 1);
                d = des_pkg::rotl28(d, 1);
            end
            else
            begin
                c = des_pkg::rotl28(c, 2);
                d = des_pkg::rotl28(d, 2);
            end
            round_keys[i] = des_pkg::perm_pc2({c, d});
        end
    end

    assign key_out = key_reg;
    assign sub_key = round_keys;

endmodule

// ===== rtl/des_round.sv =====
module des_round
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  des_pkg::round_data_t      in_data,
    input  logic [47:0]               key_enc,
    input  logic [47:0]               key_dec,
    output logic                      out_valid,
    output des_pkg::round_data_t      out_data
);

    logic                 valid_reg;
    des_pkg::round_data_t data_reg;
    des_pkg::round_data_t data_next;

    always_comb
    begin
        data_next.dec = in_data.dec;
        data_next.l   = in_data.r;
        data_next.r   = in_data.l ^ des_pkg::feistel(in_data.r,
                                                     in_data.dec ? key_dec : key_enc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/des_block_cipher.sv =====
// DES in ECB form, one 64-bit word in and one out per cycle when the output is not stalled.
// Pipeline: an input register holding the initial permutation, sixteen round registers
// (one Feistel round each) and an output register with the final permutation. The key
// is written over APB at address 0 (64-bit data) and must only change while the pipeline
// is empty. A stall freezes every stage.
module des_block_cipher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [des_pkg::AddrBits-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [63:0] block_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] block_out
);

    localparam int N = des_pkg::Rounds;

    logic        advance;
    logic        key_load;
    logic [63:0] key_value;
    logic [47:0] sub_key [N];

    logic                 in_valid_reg;
    des_pkg::round_data_t in_data_reg;
    logic                 out_valid_reg;
    logic [63:0]          block_out_reg;

    logic                 st_valid [N+1];
    des_pkg::round_data_t st_data  [N+1];
    logic [63:0]          pre_fp;

    // whole pipeline moves together unless a finished word is held
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign pready   = 1'b1;
    assign key_load = psel && penable && pwrite && (paddr == des_pkg::AddrKey);
    assign prdata   = (paddr == des_pkg::AddrKey) ? key_value : '0;

    des_key_sched u_key
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_load  (key_load),
        .key_value (pwdata),
        .key_out   (key_value),
        .sub_key   (sub_key)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_data_reg.dec <= mode;
            {in_data_reg.l, in_data_reg.r} <= des_pkg::perm_ip(block_in);
        end
    end

    assign st_valid[0] = in_valid_reg;
    assign st_data[0]  = in_data_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_round
        des_round u_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (st_valid[g]),
            .in_data   (st_data[g]),
            .key_enc   (sub_key[g]),
            .key_dec   (sub_key[N-1-g]),
            .out_valid (st_valid[g+1]),
            .out_data  (st_data[g+1])
        );
    end

    assign pre_fp = {st_data[N].r, st_data[N].l};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= st_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            block_out_reg <= des_pkg::perm_fp(pre_fp);
        end
    end

    assign out_valid = out_valid_reg;
    assign block_out = block_out_reg;

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(block_out))
        else $error("held word changed");
    a_stall_map: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && st_valid[N] |=> out_valid)
        else $error("last round word lost");

endmodule

// ===== bench/des_block_cipher_tb.sv =====
`timescale 1ns / 1ps

module des_block_cipher_tb;

    localparam int Latency = 18;
    localparam longint CycleLimit = 400000;

    typedef struct packed {
        logic        mode;
        logic [63:0] block;
    } des_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [des_pkg::AddrBits-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [63:0] block_in;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] block_out;

    des_block_cipher dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .block_in(block_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .block_out(block_out)
    );

    des_word_t   pending_words[$];
    logic [63:0] expected_blocks[$];
    logic [63:0] key_now;
    logic        in_accepted;
    int          idle_pct;
    int          stall_pct;
    int          error_count;
    int          words_sent;
    int          words_checked;
    longint      cycle_count;

    // S-box tables in row-major form, S1 first
    byte unsigned sbox_tab [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    byte unsigned ip_tab [64] = '{58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8, 57,49,41,33,25,17,9,1,
        59,51,43,35,27,19,11,3, 61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    byte unsigned fp_tab [64] = '{40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29, 36,4,44,12,52,20,60,28,
        35,3,43,11,51,19,59,27, 34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    byte unsigned e_tab [48] = '{32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13,
        12,13,14,15,16,17, 16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    byte unsigned p_tab [32] = '{16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    byte unsigned pc1_tab [56] = '{57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36, 63,55,47,39,31,23,15,
        7,62,54,46,38,30,22, 14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    byte unsigned pc2_tab [48] = '{14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8,
        16,7,27,20,13,2, 41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};
    byte unsigned shift_tab [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    // bit positions count from 1 at the msb of an in_w-bit word
    function automatic logic [63:0] bit_select(logic [63:0] v, int in_w,
                                               byte unsigned tab [], int out_w);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < out_w; i++)
            r = {r[62:0], v[in_w - int'(tab[i])]};
        return r;
    endfunction

    function automatic logic [63:0] des_crypt(logic [63:0] key, logic dec, logic [63:0] blk);
        logic [47:0] subkey [16];
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [63:0] x;
        logic [47:0] ex;
        logic [31:0] sb;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        logic [5:0]  six;
        cd = 56'(bit_select(key, 64, pc1_tab, 56));
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 16; i++)
        begin
            repeat (shift_tab[i])
            begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            subkey[i] = 48'(bit_select(64'({c, d}), 56, pc2_tab, 48));
        end
        x = bit_select(blk, 64, ip_tab, 64);
        l = x[63:32];
        r = x[31:0];
        for (int i = 0; i < 16; i++)
        begin
            ex = 48'(bit_select(64'(r), 32, e_tab, 48)) ^ (dec ? subkey[15-i] : subkey[i]);
            for (int b = 0; b < 8; b++)
            begin
                six = ex[47-6*b -: 6];
                sb[31-4*b -: 4] = 4'(sbox_tab[b][{six[5], six[0], six[4:1]}]);
            end
            t = r;
            r = l ^ 32'(bit_select(64'(sb), 32, p_tab, 32));
            l = t;
        end
        return bit_select({r, l}, 64, fp_tab, 64);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("des_block_cipher_tb: done, errors");
            $finish;
        end
    end

    // remembers whether the offered word went in at this edge
    always @(posedge clk)
    begin
        in_accepted <= in_valid && !in_stall;
    end

    // driver: offers the next word, holds it until it is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_accepted)
            begin
            end
            else if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                mode <= pending_words[0].mode;
                block_in <= pending_words[0].block;
                expected_blocks.insert(expected_blocks.size(),
                                       des_crypt(key_now, pending_words[0].mode,
                                                 pending_words[0].block));
                void'(pending_words.pop_front());
                words_sent <= words_sent + 1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_blocks.size() == 0)
            begin
                $error("block_out: no word expected, actual %h", block_out);
                error_count++;
            end
            else
            begin
                if (block_out !== expected_blocks[0])
                begin
                    $error("block_out: expected %h actual %h", expected_blocks[0], block_out);
                    error_count++;
                end
                void'(expected_blocks.pop_front());
                words_checked++;
            end
        end
    end

    task automatic write_key(logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= des_pkg::AddrKey;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        key_now = value;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_blocks.size() > 0)
            @(posedge clk);
        repeat (Latency + 4) @(posedge clk);
    endtask

    task automatic queue_word(logic m, logic [63:0] b);
        des_word_t w;
        w.mode = m;
        w.block = b;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic run_phase(int n, int idle, int stall, logic [63:0] key);
        logic [63:0] b;
        drain();
        write_key(key);
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            b = rand64();
            // mostly round trips so decrypt sees real ciphertext
            if ($urandom_range(3) != 0)
            begin
                queue_word(1'b0, b);
                queue_word(1'b1, des_crypt(key, 1'b0, b));
                i++;
            end
            else
            begin
                queue_word($urandom_range(1), b);
            end
        end
    endtask

    initial
    begin
        logic [63:0] k;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_accepted = 1'b0;
        mode = 1'b0;
        block_in = '0;
        out_stall = 1'b0;
        key_now = '0;
        idle_pct = 0;
        stall_pct = 0;
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        cycle_count = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key of zero, then the textbook vector and the extremes
        queue_word(1'b0, 64'h0);
        queue_word(1'b1, 64'h0);
        drain();
        write_key(64'h1334_5779_9BBC_DFF1);
        queue_word(1'b0, 64'h0123_4567_89AB_CDEF);
        queue_word(1'b1, 64'h85E8_1354_0F0A_B405);
        queue_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(1'b0, 64'h8000_0000_0000_0001);
        queue_word(1'b0, 64'hAAAA_AAAA_5555_5555);
        drain();
        // all-ones key, and a key with broken parity
        write_key(64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(1'b0, 64'h0);
        queue_word(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(1'b0, 64'h5555_5555_AAAA_AAAA);
        drain();
        write_key(64'h0000_0000_0000_0001);
        queue_word(1'b0, 64'h1);
        queue_word(1'b1, 64'h8000_0000_0000_0000);

        run_phase(300, 0, 0, rand64());
        run_phase(300, 53, 0, rand64());
        // sender holds off until the pipeline is empty
        drain();
        run_phase(300, 0, 53, rand64());
        run_phase(400, 14, 14, 64'h0);
        drain();
        k = rand64();
        write_key(k);

        $display("covered %0d words (%0d checked) over several keys incl. zero and all-ones,",
                 words_sent, words_checked);
        $display("both directions, round trips and idle/stall mixes");
        if (error_count == 0)
            $display("des_block_cipher_tb: done, clean");
        else
            $display("des_block_cipher_tb: done, errors");
        $finish;
    end

endmodule
